// ===== hw/rtl/u8f_pkg.sv =====
package u8f_pkg;

   localparam int unsigned CP_W = 21;

   localparam logic [1:0] ACT_NEXT = 2'd0;
   localparam logic [1:0] ACT_PASS = 2'd1;
   localparam logic [1:0] ACT_FAIL = 2'd2;

   typedef logic [3:0][7:0] seq_type;

   typedef struct packed {
      logic done;
      logic ok;
   } chk_res_type;

   typedef struct packed {
      logic [CP_W-1:0] bound;
      logic [1:0]      lt_act;
      logic [1:0]      ge_act;
   } chk_step_type;

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b[7:5] == 3'b110) begin
         n = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         n = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         n = 3'd4;
      end
      return n;
   endfunction

   // One compare per step; each step either settles the result or moves on.
   function automatic chk_step_type step_entry(input logic [2:0] len, input logic [1:0] step);
      chk_step_type e;
      e.bound  = '0;
      e.lt_act = ACT_FAIL;
      e.ge_act = ACT_FAIL;
      unique case ({len, step})
         {3'd2, 2'd0}: begin
            e.bound = 21'h00080; e.lt_act = ACT_FAIL; e.ge_act = ACT_PASS;
         end
         {3'd3, 2'd0}: begin
            e.bound = 21'h00800; e.lt_act = ACT_FAIL; e.ge_act = ACT_NEXT;
         end
         {3'd3, 2'd1}: begin
            e.bound = 21'h0D800; e.lt_act = ACT_PASS; e.ge_act = ACT_NEXT;
         end
         {3'd3, 2'd2}: begin
            e.bound = 21'h0E000; e.lt_act = ACT_FAIL; e.ge_act = ACT_PASS;
         end
         {3'd4, 2'd0}: begin
            e.bound = 21'h10000; e.lt_act = ACT_FAIL; e.ge_act = ACT_NEXT;
         end
         {3'd4, 2'd1}: begin
            e.bound = 21'h110000; e.lt_act = ACT_PASS; e.ge_act = ACT_FAIL;
         end
         default: begin
            e.bound = '0;
         end
      endcase
      return e;
   endfunction

endpackage

// ===== hw/rtl/u8f_check.sv =====
module u8f_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           len,
   input  u8f_pkg::seq_type     seq,
   output u8f_pkg::chk_res_type res
);
   import u8f_pkg::*;

   logic            busy_ff, busy_in;
   logic [1:0]      step_ff, step_in;
   logic [2:0]      len_ff, len_in;
   logic [CP_W-1:0] cp_ff, cp_in;
   logic            done_ff, done_in;
   logic            ok_ff, ok_in;
   logic [CP_W-1:0] cp_new;
   chk_step_type    info;
   logic            lt;
   logic [1:0]      act;

   always_comb begin
      cp_new = '0;
      unique case (len)
         3'd2:    cp_new = {10'd0, seq[0][4:0], seq[1][5:0]};
         3'd3:    cp_new = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
         default: cp_new = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
      endcase
   end

   assign info = step_entry(len_ff, step_ff);
   assign lt   = cp_ff < info.bound;
   assign act  = lt ? info.lt_act : info.ge_act;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      len_in  = len_ff;
      cp_in   = cp_ff;
      done_in = 1'b0;
      ok_in   = ok_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         len_in  = len;
         cp_in   = cp_new;
      end else if (busy_ff) begin
         unique case (act)
            ACT_NEXT: begin
               step_in = step_ff + 2'd1;
            end
            ACT_PASS: begin
               busy_in = 1'b0;
               done_in = 1'b1;
               ok_in   = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
               ok_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      len_ff <= len_in;
      cp_ff  <= cp_in;
      ok_ff  <= ok_in;
   end

   assign res.done = done_ff;
   assign res.ok   = ok_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("check unit started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("check result without a check");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff != 2'd3) else $error("check step out of range");
`endif

endmodule

// ===== hw/rtl/utf8_invalid_byte_filter_unit.sv =====
// Channel   Handshake             Payload
// req       req_valid/req_ready   req_in_byte, req_end_of_string
// rsp       rsp_valid/rsp_ready   rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_string_done
//
// A req transaction that completes no sequence and causes no result keeps the unit idle.
// A completed sequence is checked in the shared code point compare unit.
// Results then go out on rsp in order, each once the rsp register is free.
// The rsp register lets the next req transaction be taken while a result waits.
// Reset is synchronous and clears the held byte count and all handshake state.
module utf8_invalid_byte_filter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);
   import u8f_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]  state_ff, state_in;
   seq_type     buf_ff, buf_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [2:0]  n_ff, n_in;
   logic [1:0]  idx_ff, idx_in;
   logic [2:0]  len_ff, len_in;
   logic        eos_ff, eos_in;
   logic        start_ff, start_in;
   logic        rv_ff, rv_in;
   logic [7:0]  rbyte_ff, rbyte_in;
   logic        rbv_ff, rbv_in;
   logic        rlast_ff, rlast_in;
   logic        rdone_ff, rdone_in;

   chk_res_type chk;
   logic [2:0]  need;
   logic        extend;
   logic        complete;
   logic        out_free;
   logic        last;

   u8f_check u_check (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .len   (len_ff),
      .seq   (buf_ff),
      .res   (chk)
   );

   assign need     = seq_len(buf_ff[0]);
   assign extend   = (cnt_ff != 2'd0) && (req_in_byte[7:6] == 2'b10) && (need > {1'b0, cnt_ff});
   assign complete = extend && (({1'b0, cnt_ff} + 3'd1) == need);
   assign out_free = !rv_ff || rsp_ready;
   assign last     = (({1'b0, idx_ff} + 3'd1) == n_ff);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      eos_in   = eos_ff;
      start_in = 1'b0;
      rv_in    = rv_ff && !rsp_ready;
      rbyte_in = rbyte_ff;
      rbv_in   = rbv_ff;
      rlast_in = rlast_ff;
      rdone_in = rdone_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               eos_in = req_end_of_string;
               idx_in = 2'd0;
               n_in   = 3'd0;
               if (extend) begin
                  buf_in[cnt_ff] = req_in_byte;
                  if (complete) begin
                     cnt_in   = 2'd0;
                     len_in   = need;
                     start_in = 1'b1;
                     state_in = ST_CHECK;
                  end else begin
                     cnt_in   = req_end_of_string ? 2'd0 : cnt_ff + 2'd1;
                     state_in = req_end_of_string ? ST_EMIT : ST_IDLE;
                  end
               end else begin
                  cnt_in = 2'd0;
                  if (!req_in_byte[7]) begin
                     buf_in[0] = req_in_byte;
                     n_in      = 3'd1;
                     state_in  = ST_EMIT;
                  end else begin
                     if (seq_len(req_in_byte) != 3'd0) begin
                        buf_in[0] = req_in_byte;
                        cnt_in    = req_end_of_string ? 2'd0 : 2'd1;
                     end
                     state_in = req_end_of_string ? ST_EMIT : ST_IDLE;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (chk.done) begin
               n_in     = chk.ok ? len_ff : 3'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (n_ff == 3'd0) begin
               if (!eos_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rv_in    = 1'b1;
                  rbyte_in = 8'd0;
                  rbv_in   = 1'b0;
                  rlast_in = 1'b1;
                  rdone_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (out_free) begin
               rv_in    = 1'b1;
               rbyte_in = buf_ff[idx_ff];
               rbv_in   = 1'b1;
               rlast_in = last;
               rdone_in = last && eos_ff;
               if (last) begin
                  idx_in   = 2'd0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 2'd0;
         start_ff <= 1'b0;
         rv_ff    <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         start_ff <= start_in;
         rv_ff    <= rv_in;
         idx_ff   <= idx_in;
      end
      buf_ff   <= buf_in;
      n_ff     <= n_in;
      len_ff   <= len_in;
      eos_ff   <= eos_in;
      rbyte_ff <= rbyte_in;
      rbv_ff   <= rbv_in;
      rlast_ff <= rlast_in;
      rdone_ff <= rdone_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_out_byte    = rbyte_ff;
   assign rsp_byte_valid  = rbv_ff;
   assign rsp_run_last    = rlast_ff;
   assign rsp_string_done = rdone_ff;

`ifndef SYNTHESIS
   a_marker_ends: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rbv_ff) |-> (rdone_ff && rlast_ff)) else $error("bare marker not final");
   a_held_lead: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (seq_len(buf_ff[0]) > {1'b0, cnt_ff}))
      else $error("held bytes without a lead");
   a_check_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (cnt_ff == 2'd0)) else $error("bytes held during check");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rdone_ff) |-> rlast_ff) else $error("string end not on last result");
`endif

endmodule
